### src/qadt_pkg.sv
// Package for the quote-aware delimiter tokenizer.
// Holds the input kind codes, register indexes, quote codes and the result beat type.
// No dependencies.
package qadt_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_DELIM_BYTES  = 2'd0,
    REG_DELIM_LENGTH = 2'd1,
    REG_QUOTE_MODE   = 2'd2,
    REG_BASE_OFFSET  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;

  localparam logic [31:0] ResetDelimBytes  = 32'd44;
  localparam logic [2:0]  ResetDelimLength = 3'd1;
  localparam logic        ResetQuoteMode   = 1'b1;
  localparam logic [15:0] ResetBaseOffset  = 16'd0;

  // Fill and skip counts never exceed three, the widest delimiter minus one.
  localparam int unsigned CountW = 2;

  typedef struct packed {
    logic        overflow;
    logic        last_token;
    logic [15:0] token_length;
    logic [15:0] token_start;
  } result_t;

endpackage

### src/quote_aware_delimiter_tokenizer_core.sv
// Top level of the quote-aware delimiter tokenizer.
// Depends on qadt_pkg for codes, constants and the result beat type.
//
// Usage: a string enters one byte per beat on the s_axis channel. tuser carries the
// kind (data byte, final data byte, end of string without a byte) and tdata the byte.
// Each token leaves as one beat on m_axis with its start offset (plus base_offset)
// and length in tdata, tlast set on the final token of the string and tuser set once
// a position or length of the string has saturated.
// The configuration port writes one register per cycle; the values are latched at the
// first beat of each string, so a write takes effect with the next string.
// Throughput is one input beat per cycle while s_axis_tready is high. The delimiter
// compare over the window is parallel, so every byte is handled in the cycle it is
// accepted; a final byte that closes a token at a delimiter as well yields two result
// beats. Each result beat is registered in the output FIFO before it shows on m_axis.
// Results queue in a four-entry output FIFO; s_axis_tready stays high while two entries
// are free, so a stalled receiver holds the input back once fewer than two are free.
// Reset clears all string state, empties the FIFO and restores the register defaults
// (delimiter ",", length 1, quote mode on, base offset 0).
module quote_aware_delimiter_tokenizer_core #(
  parameter int unsigned MAX_DELIM_BYTES = 4,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
  output logic        m_axis_tlast,   // last_token
  output logic        m_axis_tuser    // [0] overflow
);

  localparam int unsigned Cap      = (MAX_DELIM_BYTES < 4) ? MAX_DELIM_BYTES : 4;
  localparam int unsigned WinDepth = (Cap > 1) ? Cap - 1 : 1;
  localparam int unsigned WinBits  = WinDepth * 8;
  localparam int unsigned ExtBits  = Cap * 8 + 8;
  localparam int unsigned PosW     = POSITION_BITS;
  localparam int unsigned SumW     = ((PosW > 16) ? PosW : 16) + 1;
  localparam logic [SumW-1:0] PosMax = SumW'((64'd1 << PosW) - 64'd1);
  localparam logic [2:0] CapLen = 3'(Cap);

  // Returns {saturated, value} for the sum of two values below the saturation limit.
  function automatic logic [PosW:0] sat_add(input logic [SumW-1:0] a,
                                            input logic [SumW-1:0] b);
    logic [SumW-1:0] s;
    s = a + b;
    if (s > PosMax) begin
      return {1'b1, {PosW{1'b1}}};
    end
    return {1'b0, s[PosW-1:0]};
  endfunction

  // Configuration registers.
  logic [31:0] cfg_bytes_q;
  logic [2:0]  cfg_len_q;
  logic        cfg_qmode_q;
  logic [15:0] cfg_base_q;

  // Per-string latched configuration.
  logic        act_q, act_d;
  logic [31:0] lat_bytes_q, lat_bytes_d;
  logic [2:0]  lat_len_q, lat_len_d;
  logic        lat_qmode_q, lat_qmode_d;
  logic [15:0] lat_base_q, lat_base_d;

  // String state.
  logic [WinBits-1:0]        pend_q, pend_d;
  logic [qadt_pkg::CountW-1:0] fill_q, fill_d;
  logic [qadt_pkg::CountW-1:0] skip_q, skip_d;
  qadt_pkg::quote_e          qc_q, qc_d;
  logic                      ign_q, ign_d;
  logic [PosW-1:0]           start_q, start_d;
  logic [PosW-1:0]           len_q, len_d;
  logic                      ov_q, ov_d;

  // Output FIFO.
  qadt_pkg::result_t fifo_q [4];
  logic [1:0] head_q;
  logic [2:0] cnt_q;
  logic [1:0] tail;
  logic       pop;

  logic       accept;
  logic [1:0] n_res;
  qadt_pkg::result_t res0, res1;

  // Combinational working values.
  logic [2:0]  clamp_len, eff_len, fill_p1, rem, nskip, add_n;
  logic [31:0] eff_bytes;
  logic        eff_qmode;
  logic [15:0] eff_base;
  logic        do_step, do_finish, handle, match, quote_hit;
  logic [7:0]  b, c, wk;
  logic [ExtBits-1:0] pend_ext, pend_new;
  logic [PosW:0] s_emit, s_mid, s_next, s_len;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (cnt_q <= 3'd2);
  assign b             = s_axis_tdata;

  always_comb begin
    clamp_len = cfg_len_q;
    if (cfg_len_q == 3'd0) begin
      clamp_len = 3'd1;
    end else if (cfg_len_q > CapLen) begin
      clamp_len = CapLen;
    end
  end

  assign eff_len   = act_q ? lat_len_q   : clamp_len;
  assign eff_bytes = act_q ? lat_bytes_q : cfg_bytes_q;
  assign eff_qmode = act_q ? lat_qmode_q : cfg_qmode_q;
  assign eff_base  = act_q ? lat_base_q  : cfg_base_q;

  assign pend_ext = ExtBits'(pend_q);

  always_comb begin
    act_d       = act_q;
    lat_bytes_d = lat_bytes_q;
    lat_len_d   = lat_len_q;
    lat_qmode_d = lat_qmode_q;
    lat_base_d  = lat_base_q;
    pend_d      = pend_q;
    fill_d      = fill_q;
    skip_d      = skip_q;
    qc_d        = qc_q;
    ign_d       = ign_q;
    start_d     = start_q;
    len_d       = len_q;
    ov_d        = ov_q;
    n_res       = 2'd0;
    res0        = '0;
    res1        = '0;
    do_step     = 1'b0;
    do_finish   = 1'b0;
    handle      = 1'b0;
    match       = 1'b0;
    quote_hit   = 1'b0;
    fill_p1     = 3'd0;
    rem         = 3'd0;
    nskip       = 3'd0;
    add_n       = 3'd0;
    c           = 8'd0;
    wk          = 8'd0;
    pend_new    = pend_ext;
    s_emit      = '0;
    s_mid       = '0;
    s_next      = '0;
    s_len       = '0;

    if (accept) begin
      case (s_axis_tuser)
        qadt_pkg::KIND_DATA: begin
          do_step = 1'b1;
        end
        qadt_pkg::KIND_FINAL: begin
          do_step   = 1'b1;
          do_finish = 1'b1;
        end
        qadt_pkg::KIND_END: begin
          do_finish = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if ((do_step || do_finish) && !act_q) begin
      act_d       = 1'b1;
      lat_bytes_d = cfg_bytes_q;
      lat_len_d   = clamp_len;
      lat_qmode_d = cfg_qmode_q;
      lat_base_d  = cfg_base_q;
    end

    if (do_step) begin
      fill_p1 = {1'b0, fill_q} + 3'd1;
      handle  = (fill_p1 == eff_len);
      if (handle) begin
        // The window is full: the oldest byte is decided and leaves the window.
        c = (eff_len == 3'd1) ? b : pend_ext[7:0];
        for (int k = 0; k < Cap; k++) begin
          pend_new[8*k +: 8] = (3'(k + 2) == eff_len) ? b : pend_ext[8*(k+1) +: 8];
        end
        fill_d = qadt_pkg::CountW'(eff_len - 3'd1);
        if (skip_q != '0) begin
          skip_d = skip_q - qadt_pkg::CountW'(1);
        end else begin
          if (eff_qmode) begin
            if (qc_q == qadt_pkg::QUOTE_NONE) begin
              if (c == qadt_pkg::CharDquote) begin
                qc_d  = qadt_pkg::QUOTE_DOUBLE;
                ign_d = 1'b1;
              end else if (c == qadt_pkg::CharSquote) begin
                qc_d  = qadt_pkg::QUOTE_SINGLE;
                ign_d = 1'b1;
              end
            end else begin
              quote_hit = (qc_q == qadt_pkg::QUOTE_DOUBLE) ? (c == qadt_pkg::CharDquote)
                                                            : (c == qadt_pkg::CharSquote);
              if (quote_hit) begin
                ign_d = !ign_q;
              end
            end
          end
          match = !ign_d;
          for (int k = 0; k < Cap; k++) begin
            wk = (3'(k + 1) == eff_len) ? b : pend_ext[8*k +: 8];
            if ((3'(k) < eff_len) && (wk != eff_bytes[8*k +: 8])) begin
              match = 1'b0;
            end
          end
          if (match) begin
            s_emit = sat_add(SumW'(start_q), SumW'(eff_base));
            n_res  = 2'd1;
            res0.token_start  = 16'(s_emit[PosW-1:0]);
            res0.token_length = 16'(len_q);
            res0.last_token   = 1'b0;
            res0.overflow     = ov_q || s_emit[PosW];
            s_mid   = sat_add(SumW'(start_q), SumW'(len_q));
            s_next  = sat_add(SumW'(s_mid[PosW-1:0]), SumW'(eff_len));
            start_d = s_next[PosW-1:0];
            len_d   = '0;
            skip_d  = qadt_pkg::CountW'(eff_len - 3'd1);
            ov_d    = ov_q || s_emit[PosW] || s_mid[PosW] || s_next[PosW];
          end else begin
            s_len = sat_add(SumW'(len_q), SumW'(1'b1));
            len_d = s_len[PosW-1:0];
            ov_d  = ov_q || s_len[PosW];
          end
        end
      end else begin
        for (int k = 0; k < Cap; k++) begin
          if (3'(k) == {1'b0, fill_q}) begin
            pend_new[8*k +: 8] = b;
          end
        end
        fill_d = qadt_pkg::CountW'(fill_p1);
      end
      pend_d = pend_new[WinBits-1:0];
    end

    if (do_finish) begin
      // Tail bytes cannot start a delimiter: each one is skipped or added to the token.
      rem   = {1'b0, fill_d};
      nskip = ({1'b0, skip_d} < rem) ? {1'b0, skip_d} : rem;
      add_n = rem - nskip;
      s_len  = sat_add(SumW'(len_d), SumW'(add_n));
      s_emit = sat_add(SumW'(start_d), SumW'(eff_base));
      if (n_res == 2'd1) begin
        n_res = 2'd2;
        res1.token_start  = 16'(s_emit[PosW-1:0]);
        res1.token_length = 16'(s_len[PosW-1:0]);
        res1.last_token   = 1'b1;
        res1.overflow     = ov_d || s_len[PosW] || s_emit[PosW];
      end else begin
        n_res = 2'd1;
        res0.token_start  = 16'(s_emit[PosW-1:0]);
        res0.token_length = 16'(s_len[PosW-1:0]);
        res0.last_token   = 1'b1;
        res0.overflow     = ov_d || s_len[PosW] || s_emit[PosW];
      end
      act_d   = 1'b0;
      fill_d  = '0;
      skip_d  = '0;
      qc_d    = qadt_pkg::QUOTE_NONE;
      ign_d   = 1'b0;
      start_d = '0;
      len_d   = '0;
      ov_d    = 1'b0;
    end
  end

  assign tail = head_q + cnt_q[1:0];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bytes_q <= qadt_pkg::ResetDelimBytes;
      cfg_len_q   <= qadt_pkg::ResetDelimLength;
      cfg_qmode_q <= qadt_pkg::ResetQuoteMode;
      cfg_base_q  <= qadt_pkg::ResetBaseOffset;
      act_q       <= 1'b0;
      lat_bytes_q <= qadt_pkg::ResetDelimBytes;
      lat_len_q   <= qadt_pkg::ResetDelimLength;
      lat_qmode_q <= qadt_pkg::ResetQuoteMode;
      lat_base_q  <= qadt_pkg::ResetBaseOffset;
      fill_q      <= '0;
      skip_q      <= '0;
      qc_q        <= qadt_pkg::QUOTE_NONE;
      ign_q       <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      ov_q        <= 1'b0;
      head_q      <= 2'd0;
      cnt_q       <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          qadt_pkg::REG_DELIM_BYTES:  cfg_bytes_q <= cfg_wdata_i;
          qadt_pkg::REG_DELIM_LENGTH: cfg_len_q   <= cfg_wdata_i[2:0];
          qadt_pkg::REG_QUOTE_MODE:   cfg_qmode_q <= cfg_wdata_i[0];
          qadt_pkg::REG_BASE_OFFSET:  cfg_base_q  <= cfg_wdata_i[15:0];
          default: begin
          end
        endcase
      end
      act_q       <= act_d;
      lat_bytes_q <= lat_bytes_d;
      lat_len_q   <= lat_len_d;
      lat_qmode_q <= lat_qmode_d;
      lat_base_q  <= lat_base_d;
      fill_q      <= fill_d;
      skip_q      <= skip_d;
      qc_q        <= qc_d;
      ign_q       <= ign_d;
      start_q     <= start_d;
      len_q       <= len_d;
      ov_q        <= ov_d;
      if (pop) begin
        head_q <= head_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, n_res} - {2'b00, pop};
    end
  end

  // Window bytes and FIFO entries are payload and need no reset.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (n_res != 2'd0) begin
      fifo_q[tail] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_q[tail + 2'd1] <= res1;
    end
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = {fifo_q[head_q].token_length, fifo_q[head_q].token_start};
  assign m_axis_tlast  = fifo_q[head_q].last_token;
  assign m_axis_tuser  = fifo_q[head_q].overflow;

endmodule
